@@ src/hfd_pkg.sv @@
// ----------------------------------------------------------------------------
// hfd_pkg
// Shared types, codes and constants of the Huffman tree-walk decoder.
// ----------------------------------------------------------------------------
package hfd_pkg;

   // Default node table depth.
   localparam int MAX_NODES_DEF = 512;

   // Field widths.
   localparam int IDX_W    = 9;
   localparam int PTR_W    = 10;
   localparam int SYM_W    = 8;
   localparam int CNT_W    = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Stream payload widths (rounded up to whole bytes).
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   // Request kinds.
   localparam logic REQ_NODE_WRITE = 1'b0;
   localparam logic REQ_CODE_BIT   = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_TREE = 2'd2;

   // Register indexes (selected by address bit 2).
   localparam logic REG_ROOT_NODE        = 1'b0;
   localparam logic REG_SYMBOLS_EXPECTED = 1'b1;

   // One node table entry; a negative child means none.
   typedef struct packed {
      logic signed [PTR_W-1:0] left;
      logic signed [PTR_W-1:0] right;
      logic [SYM_W-1:0]        sym;
   } node_type;

   // Configuration seen by the walker.
   typedef struct packed {
      logic signed [PTR_W-1:0] root_node;
      logic [CNT_W-1:0]        symbols_expected;
      logic                    root_wr;
      logic                    cfg_wr;
   } cfg_type;

   // One accepted input beat, decoded.
   typedef struct packed {
      logic             bit_en;
      logic             wr_en;
      logic [IDX_W-1:0] node_index;
      node_type         node;
      logic             code_bit;
   } item_type;

   // One step result.
   typedef struct packed {
      logic                valid;
      logic [SYM_W-1:0]    symbol;
      logic [STATUS_W-1:0] status;
      logic                last;
   } result_type;

   // Walker sequencer states.
   typedef enum logic [1:0] {
      ST_RUN,
      ST_FETCH_ROOT,
      ST_FETCH_RKIDS,
      ST_FETCH_CKIDS
   } walk_state_type;

   // Which cached entry a memory read port is filling.
   typedef enum logic [2:0] {
      LAND_NONE,
      LAND_RT,
      LAND_RL,
      LAND_RR,
      LAND_CL,
      LAND_CR
   } land_type;

   // A node with no children is a leaf.
   function automatic logic is_leaf(input node_type n);
      return n.left[PTR_W-1] && n.right[PTR_W-1];
   endfunction

endpackage

@@ src/hfd_node_mem.sv @@
// ----------------------------------------------------------------------------
// hfd_node_mem
// Node table memory: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module hfd_node_mem #(
   parameter int DEPTH = hfd_pkg::MAX_NODES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  hfd_pkg::node_type wr_data,
   input  logic [AW-1:0]    rd_a_addr,
   input  logic [AW-1:0]    rd_b_addr,
   output hfd_pkg::node_type rd_a_data,
   output hfd_pkg::node_type rd_b_data
);

   hfd_pkg::node_type mem [DEPTH];
   hfd_pkg::node_type rd_a_ff;
   hfd_pkg::node_type rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports with registered data.
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ src/hfd_csr.sv @@
// ----------------------------------------------------------------------------
// hfd_csr
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module hfd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [hfd_pkg::CSR_AW-1:0]    paddr,
   input  logic [hfd_pkg::CSR_DW-1:0]    pwdata,
   output logic [hfd_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready,
   output hfd_pkg::cfg_type              cfg
);

   logic signed [hfd_pkg::PTR_W-1:0] root_ff;
   logic signed [hfd_pkg::PTR_W-1:0] root_in;
   logic [hfd_pkg::CNT_W-1:0]        expected_ff;
   logic [hfd_pkg::CNT_W-1:0]        expected_in;
   logic                             wr_root;
   logic                             wr_expected;

   // Write decode; the register index is address bit 2.
   always_comb begin
      wr_root     = 1'b0;
      wr_expected = 1'b0;
      if (psel && penable && pwrite) begin
         case (paddr[2])
            hfd_pkg::REG_ROOT_NODE:        wr_root     = 1'b1;
            hfd_pkg::REG_SYMBOLS_EXPECTED: wr_expected = 1'b1;
            default:                       wr_root     = 1'b0;
         endcase
      end
      root_in     = wr_root ? pwdata[hfd_pkg::PTR_W-1:0] : root_ff;
      expected_in = wr_expected ? pwdata : expected_ff;
   end

   // Registers; the root resets to "no tree".
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff     <= '1;
         expected_ff <= '0;
      end else begin
         root_ff     <= root_in;
         expected_ff <= expected_in;
      end
   end

   // Read mux.
   always_comb begin
      case (paddr[2])
         hfd_pkg::REG_ROOT_NODE:
            prdata = {{(hfd_pkg::CSR_DW - hfd_pkg::PTR_W){root_ff[hfd_pkg::PTR_W-1]}}, root_ff};
         hfd_pkg::REG_SYMBOLS_EXPECTED:
            prdata = expected_ff;
         default:
            prdata = '0;
      endcase
   end

   assign pready               = 1'b1;
   assign cfg.root_node        = root_ff;
   assign cfg.symbols_expected = expected_ff;
   assign cfg.root_wr          = wr_root;
   assign cfg.cfg_wr           = wr_root || wr_expected;

endmodule

@@ src/hfd_walk.sv @@
// ----------------------------------------------------------------------------
// hfd_walk
// Tree walker: cached root and current node with their children, the node
// table, the cursor, the symbol count and a refetch sequencer.
// ----------------------------------------------------------------------------
module hfd_walk #(
   parameter int MAX_NODES = hfd_pkg::MAX_NODES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  hfd_pkg::cfg_type    cfg,
   input  hfd_pkg::item_type   item,
   output logic                run,
   output hfd_pkg::result_type result
);

   localparam int AW = $clog2(MAX_NODES);
   localparam int IW = hfd_pkg::IDX_W;
   localparam int PW = hfd_pkg::PTR_W;

   hfd_pkg::walk_state_type state_ff, state_in;
   hfd_pkg::land_type       land_a_ff, land_a_in;
   hfd_pkg::land_type       land_b_ff, land_b_in;
   logic                    pend_ckids_ff, pend_ckids_in;
   hfd_pkg::node_type       rt_ff, rt_in, rl_ff, rl_in, rr_ff, rr_in;
   hfd_pkg::node_type       cur_ff, cur_in, cl_ff, cl_in, cr_ff, cr_in;
   logic [IW-1:0]           cur_idx_ff, cur_idx_in;
   logic                    at_root_ff, at_root_in;
   logic [hfd_pkg::CNT_W-1:0] count_ff, count_in, count_inc;

   hfd_pkg::node_type rd_a_data, rd_b_data;
   logic [AW-1:0]     rd_a_addr, rd_b_addr;
   hfd_pkg::node_type rt_e, rl_e, rr_e, cl_e, cr_e;
   hfd_pkg::node_type par, ne;
   logic signed [PW-1:0] nptr;
   logic [IW-1:0]     root_idx;
   logic              root_ok, done, descend, wr_ok, wr_hit_root, wr_hit_cur;

   // A pointer names a node when it is non-negative and inside the table.
   function automatic logic ptr_ok(input logic signed [PW-1:0] p);
      return !p[PW-1] && (32'(p[IW-1:0]) < MAX_NODES);
   endfunction

   // A node write lands on the entry that a valid pointer names.
   function automatic logic wr_hits(input logic signed [PW-1:0] p, input logic en,
                                    input logic [IW-1:0] idx);
      return en && !p[PW-1] && (p[IW-1:0] == idx);
   endfunction

   // Node table.
   hfd_node_mem #(.DEPTH(MAX_NODES), .AW(AW)) u_mem (
      .clock     (clock),
      .wr_en     (wr_ok),
      .wr_addr   (AW'(item.node_index)),
      .wr_data   (item.node),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // Cached entries, taking read data in the cycle it lands.
   assign rt_e = (land_a_ff == hfd_pkg::LAND_RT) ? rd_a_data : rt_ff;
   assign rl_e = (land_a_ff == hfd_pkg::LAND_RL) ? rd_a_data : rl_ff;
   assign cl_e = (land_a_ff == hfd_pkg::LAND_CL) ? rd_a_data : cl_ff;
   assign rr_e = (land_b_ff == hfd_pkg::LAND_RR) ? rd_b_data : rr_ff;
   assign cr_e = (land_b_ff == hfd_pkg::LAND_CR) ? rd_b_data : cr_ff;

   // Root, write hits and the chosen child.
   assign root_idx    = cfg.root_node[IW-1:0];
   assign root_ok     = ptr_ok(cfg.root_node);
   assign wr_ok       = item.wr_en && (32'(item.node_index) < MAX_NODES);
   assign wr_hit_root = wr_ok && root_ok && (item.node_index == root_idx);
   assign wr_hit_cur  = wr_ok && !at_root_ff && (item.node_index == cur_idx_ff);
   assign par         = at_root_ff ? rt_e : cur_ff;
   assign nptr        = item.code_bit ? par.right : par.left;
   assign ne          = at_root_ff ? (item.code_bit ? rr_e : rl_e)
                                   : (item.code_bit ? cr_e : cl_e);
   assign count_inc   = count_ff + hfd_pkg::CNT_W'(1);
   assign done        = count_ff >= cfg.symbols_expected;

   // One tree step per code bit; node writes refresh matching cache entries.
   always_comb begin
      result     = '0;
      descend    = 1'b0;
      rt_in      = wr_hit_root ? item.node : rt_e;
      rl_in      = wr_hits(rt_e.left, wr_ok, item.node_index) ? item.node : rl_e;
      rr_in      = wr_hits(rt_e.right, wr_ok, item.node_index) ? item.node : rr_e;
      cur_in     = wr_hit_cur ? item.node : cur_ff;
      cl_in      = wr_hits(cur_ff.left, wr_ok, item.node_index) ? item.node : cl_e;
      cr_in      = wr_hits(cur_ff.right, wr_ok, item.node_index) ? item.node : cr_e;
      cur_idx_in = cur_idx_ff;
      at_root_in = at_root_ff;
      count_in   = count_ff;
      if (cfg.cfg_wr) begin
         count_in   = '0;
         at_root_in = 1'b1;
      end else if (item.bit_en) begin
         if (!root_ok) begin
            result.valid  = 1'b1;
            result.status = hfd_pkg::STATUS_NO_TREE;
         end else if (!done) begin
            if (hfd_pkg::is_leaf(rt_e)) begin
               result.valid  = 1'b1;
               result.symbol = rt_e.sym;
               result.status = hfd_pkg::STATUS_OK;
               result.last   = (count_inc == cfg.symbols_expected);
               count_in      = count_inc;
               at_root_in    = 1'b1;
            end else if (!ptr_ok(nptr)) begin
               result.valid  = 1'b1;
               result.status = hfd_pkg::STATUS_INVALID;
               at_root_in    = 1'b1;
            end else if (hfd_pkg::is_leaf(ne)) begin
               result.valid  = 1'b1;
               result.symbol = ne.sym;
               result.status = hfd_pkg::STATUS_OK;
               result.last   = (count_inc == cfg.symbols_expected);
               count_in      = count_inc;
               at_root_in    = 1'b1;
            end else begin
               descend    = 1'b1;
               cur_in     = ne;
               cur_idx_in = nptr[IW-1:0];
               at_root_in = 1'b0;
            end
         end
      end
   end

   // Sequencer next state: refetch the root when root_node is written, and children whose parent pointers changed.
   always_comb begin
      state_in      = state_ff;
      pend_ckids_in = pend_ckids_ff;
      if (cfg.root_wr) begin
         state_in      = hfd_pkg::ST_FETCH_ROOT;
         pend_ckids_in = 1'b0;
      end else begin
         case (state_ff)
            hfd_pkg::ST_RUN: begin
               if (wr_hit_root) begin
                  state_in      = hfd_pkg::ST_FETCH_RKIDS;
                  pend_ckids_in = wr_hit_cur;
               end else if (wr_hit_cur) begin
                  state_in = hfd_pkg::ST_FETCH_CKIDS;
               end
            end
            hfd_pkg::ST_FETCH_ROOT: begin
               state_in = root_ok ? hfd_pkg::ST_FETCH_RKIDS : hfd_pkg::ST_RUN;
            end
            hfd_pkg::ST_FETCH_RKIDS: begin
               state_in      = pend_ckids_ff ? hfd_pkg::ST_FETCH_CKIDS : hfd_pkg::ST_RUN;
               pend_ckids_in = 1'b0;
            end
            hfd_pkg::ST_FETCH_CKIDS: begin
               state_in = hfd_pkg::ST_RUN;
            end
            default: begin
               state_in = hfd_pkg::ST_RUN;
            end
         endcase
      end
   end

   // Sequencer outputs: read addresses and where the read data lands.
   always_comb begin
      run       = 1'b0;
      rd_a_addr = AW'(ne.left[IW-1:0]);
      rd_b_addr = AW'(ne.right[IW-1:0]);
      land_a_in = hfd_pkg::LAND_NONE;
      land_b_in = hfd_pkg::LAND_NONE;
      case (state_ff)
         hfd_pkg::ST_RUN: begin
            run = 1'b1;
            if (descend) begin
               land_a_in = hfd_pkg::LAND_CL;
               land_b_in = hfd_pkg::LAND_CR;
            end
         end
         hfd_pkg::ST_FETCH_ROOT: begin
            rd_a_addr = AW'(root_idx);
            land_a_in = hfd_pkg::LAND_RT;
         end
         hfd_pkg::ST_FETCH_RKIDS: begin
            rd_a_addr = AW'(rt_e.left[IW-1:0]);
            rd_b_addr = AW'(rt_e.right[IW-1:0]);
            land_a_in = hfd_pkg::LAND_RL;
            land_b_in = hfd_pkg::LAND_RR;
         end
         hfd_pkg::ST_FETCH_CKIDS: begin
            rd_a_addr = AW'(cur_ff.left[IW-1:0]);
            rd_b_addr = AW'(cur_ff.right[IW-1:0]);
            land_a_in = hfd_pkg::LAND_CL;
            land_b_in = hfd_pkg::LAND_CR;
         end
         default: begin
            run = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hfd_pkg::ST_RUN;
         land_a_ff     <= hfd_pkg::LAND_NONE;
         land_b_ff     <= hfd_pkg::LAND_NONE;
         pend_ckids_ff <= 1'b0;
         at_root_ff    <= 1'b1;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         land_a_ff     <= land_a_in;
         land_b_ff     <= land_b_in;
         pend_ckids_ff <= pend_ckids_in;
         at_root_ff    <= at_root_in;
         count_ff      <= count_in;
      end
   end

   // Cached node entries.
   always_ff @(posedge clock) begin
      rt_ff      <= rt_in;
      rl_ff      <= rl_in;
      rr_ff      <= rr_in;
      cur_ff     <= cur_in;
      cl_ff      <= cl_in;
      cr_ff      <= cr_in;
      cur_idx_ff <= cur_idx_in;
   end

endmodule

@@ src/huffman_tree_walk_decoder.sv @@
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// Decodes a Huffman bit stream by walking a node table, one bit per beat.
// ----------------------------------------------------------------------------
// Usage:
// The req stream carries node writes (tuser 0) and code bits (tuser 1).
// Node writes load the table and give no result. Each code bit moves the
// cursor one level; a leaf, a missing child or a missing tree gives one
// rsp beat (symbol in tdata, status in tuser, tlast on the final symbol).
// A result appears on rsp in the cycle after its bit is accepted, and one
// bit or node write is taken every cycle but during a refetch or rsp
// stall. Root and current node are cached with both children; the chosen
// child's children are read from the two-port node table as the cursor
// descends. A node write to the root or current node stalls req while its
// children are refetched; a root_node write, while the root and, if it
// names a tree, its children are fetched. The csr port sets root_node and
// symbols_expected; any write clears the symbol count and returns to root.
// Reset clears the count, returns the cursor to the root and sets the root
// to "no tree"; the table holds no data until written. When rsp stalls, the
// held result waits in its register and req_tready drops until it is taken.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder #(
   parameter int MAX_NODES = hfd_pkg::MAX_NODES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: node_index[8:0], left_child[18:9], right_child[28:19],
   //        leaf_symbol[36:29], code_bit[37], zero[39:38]
   input  logic [hfd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: req_type[0]
   input  logic                               req_tuser,
   // Result stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: symbol[7:0]
   output logic [hfd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: status[1:0]
   output logic [hfd_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic                               rsp_tlast,
   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hfd_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [hfd_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [hfd_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                               csr_pready
);

   hfd_pkg::cfg_type    cfg;
   hfd_pkg::item_type   item;
   hfd_pkg::result_type result;
   logic                run;
   logic                req_beat;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [hfd_pkg::SYM_W-1:0]    rsp_symbol_ff, rsp_symbol_in;
   logic [hfd_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   // Configuration registers.
   hfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Input beat unpack.
   assign req_tready      = run && (!rsp_valid_ff || rsp_tready);
   assign req_beat        = req_tvalid && req_tready;
   assign item.bit_en     = req_beat && (req_tuser == hfd_pkg::REQ_CODE_BIT);
   assign item.wr_en      = req_beat && (req_tuser == hfd_pkg::REQ_NODE_WRITE);
   assign item.node_index = req_tdata[8:0];
   assign item.node.left  = req_tdata[18:9];
   assign item.node.right = req_tdata[28:19];
   assign item.node.sym   = req_tdata[36:29];
   assign item.code_bit   = req_tdata[37];

   // Tree walker.
   hfd_walk #(.MAX_NODES(MAX_NODES)) u_walk (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (item),
      .run    (run),
      .result (result)
   );

   // Result register: loads a new beat as the held one leaves.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (result.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = result.symbol;
         rsp_status_in = result.status;
         rsp_last_in   = result.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_symbol_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // A failed step never carries a symbol or the final-symbol mark.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != hfd_pkg::STATUS_OK) |-> (!rsp_tlast && rsp_tdata == '0))
      else $error("failed step carries symbol or last mark");

   // A new root always triggers a table fetch before bits are taken again.
   a_root_fetch: assert property (@(posedge clock) disable iff (reset)
      cfg.root_wr |=> !req_tready)
      else $error("input taken during root fetch");

   // A held result blocks the input side.
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while result is stalled");
`endif

endmodule
